// ===== design/sha_pkg.sv =====
`default_nettype none
package sha_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    typedef struct packed {
        logic       byte_wr;
        logic       pad_wr;
        logic       len_wr;
        logic       zero_wr;
        logic [5:0] pad_addr;
        logic       load_start;
        logic       load_step;
        logic       round_en;
        logic       fold;
        logic       reinit;
        logic       clear_len;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] position;
        logic [5:0] round;
    } sha_stat_t;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ===== design/sha_datapath.sv =====
`default_nettype none
module sha_datapath
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sha_cmd_t    cmd,
    input  wire logic [7:0]  data_byte,
    input  wire logic [2:0]  out_sel,
    output sha_stat_t        stat,
    output logic [31:0]      digest_word
);

    // byte buffer: 16 words, byte-lane writes, one registered word read
    logic [31:0] buf_mem [16];
    logic [3:0]  rd_word_reg;
    logic [31:0] rd_data_reg;
    logic [5:0]  pos_reg;
    logic [63:0] len_reg;
    logic [5:0]  round_reg;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];

    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic       wr_en;

    always_comb
    begin
        wr_en   = cmd.byte_wr | cmd.pad_wr | cmd.len_wr | cmd.zero_wr;
        wr_addr = cmd.byte_wr ? pos_reg : cmd.pad_addr;
        wr_data = 8'h00;
        if (cmd.byte_wr)
            wr_data = data_byte;
        else if (cmd.pad_wr)
            wr_data = PAD_BYTE;
        else if (cmd.len_wr)
            wr_data = len_reg[8 * (7 - cmd.pad_addr[2:0]) +: 8];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[wr_addr[5:2]][8 * (3 - wr_addr[1:0]) +: 8] <= wr_data;
        rd_data_reg <= buf_mem[rd_word_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            len_reg     <= '0;
            rd_word_reg <= '0;
        end
        else
        begin
            if (cmd.byte_wr)
            begin
                pos_reg <= pos_reg + 6'd1;
                len_reg <= len_reg + 64'd8;
            end
            if (cmd.clear_len)
            begin
                pos_reg <= '0;
                len_reg <= '0;
            end
            if (cmd.load_start)
                rd_word_reg <= 4'd1;
            else if (cmd.load_step)
                rd_word_reg <= rd_word_reg + 4'd1;
            else
                rd_word_reg <= '0;
        end
    end

    // schedule and round
    logic [31:0] w_cur, w_new, s0, s1, t1, t2, e, a;
    always_comb
    begin
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = (round_reg < 6'd16) ? w_reg[0] : w_new;
        e  = v_reg[4];
        a  = v_reg[0];
        t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
             + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[round_reg] + w_cur;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_step)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= rd_data_reg;
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_cur;
        end
        if (cmd.load_start)
            v_reg <= h_reg;
        else if (cmd.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= '0;
            h_reg     <= INIT_HASH;
        end
        else
        begin
            if (cmd.load_start)
                round_reg <= '0;
            else if (cmd.round_en)
                round_reg <= round_reg + 6'd1;
            if (cmd.fold)
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            else if (cmd.reinit)
                h_reg <= INIT_HASH;
        end
    end

    assign stat.position = pos_reg;
    assign stat.round    = round_reg;
    assign digest_word   = h_reg[out_sel];

endmodule
`default_nettype wire

// ===== design/sha_control.sv =====
`default_nettype none
module sha_control
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             ready,
    input  wire logic        byte_present,
    input  wire logic        message_end,
    input  wire sha_stat_t   stat,
    output sha_cmd_t         cmd,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       out_sel
);

    sha_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;     // load count
    logic [5:0] pad_reg, pad_next;     // padding address
    logic       final_reg, final_next; // compressing a padded block
    logic       end_reg, end_next;     // message end pending
    logic [2:0] sel_reg, sel_next;

    // pad byte already placed when padding wrapped into a second block
    logic pad_pending;
    logic pad_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pad_reg   <= '0;
            final_reg <= 1'b0;
            end_reg   <= 1'b0;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pad_reg   <= pad_next;
            final_reg <= final_next;
            end_reg   <= end_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pad_next   = pad_reg;
        final_next = final_reg;
        end_next   = end_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        ready      = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (valid)
                begin
                    cmd.byte_wr = byte_present;
                    end_next    = message_end;
                    final_next  = 1'b0;
                    if (byte_present && stat.position == 6'd63)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                    end
                    else if (message_end)
                    begin
                        // pad byte goes where the next byte would
                        pad_next   = stat.position + (byte_present ? 6'd1 : 6'd0);
                        cmd.pad_wr = 1'b0;
                        state_next = ST_PAD;
                        final_next = 1'b0;
                        cnt_next   = 5'd1; // pad byte not yet written
                    end
                end
            end
            ST_PAD:
            begin
                // cnt_reg=1: write 0x80; then zeros to 56 (or 64), then length
                cmd.pad_addr = pad_reg;
                if (cnt_reg == 5'd1)
                begin
                    cmd.pad_wr = 1'b1;
                    cnt_next   = '0;
                    pad_next   = pad_reg + 6'd1;
                    if (pad_reg == 6'd63)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                    end
                    else if (pad_reg > LEN_OFFSET - 6'd1)
                        final_next = 1'b0;
                end
                else if (pad_reg < LEN_OFFSET || !final_reg && pad_reg >= LEN_OFFSET
                         && cnt_reg == 5'd2)
                begin
                    cmd.zero_wr = 1'b1;
                    pad_next    = pad_reg + 6'd1;
                    if (pad_reg == 6'd63)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                    end
                end
                else
                begin
                    cmd.len_wr = 1'b1;
                    pad_next   = pad_reg + 6'd1;
                    if (pad_reg == 6'd63)
                    begin
                        final_next = 1'b1;
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                    end
                end
                // a block with the pad byte past offset 55 is zero filled
                if (cnt_reg == 5'd1 && pad_reg >= LEN_OFFSET && pad_reg != 6'd63)
                    cnt_next = 5'd2;
                if (cnt_reg == 5'd2 && state_next == ST_LOAD)
                    cnt_next = '0;
            end
            ST_LOAD:
            begin
                if (cnt_reg == 5'd0)
                    cmd.load_start = 1'b1;
                else
                    cmd.load_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (stat.round == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (final_reg)
                begin
                    state_next = ST_EMIT;
                    sel_next   = '0;
                end
                else if (end_reg)
                begin
                    state_next = ST_PAD;
                    // full block just done: pad from 0; overflow block: zeros then len
                    cnt_next   = (pad_reg == 6'd0 && !pad_pending) ? 5'd1 : 5'd3;
                    pad_next   = '0;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    sel_next = sel_reg + 3'd1;
                    if (sel_reg == 3'd7)
                    begin
                        cmd.reinit    = 1'b1;
                        cmd.clear_len = 1'b1;
                        end_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_done_reg <= 1'b0;
        else if (state_reg == ST_IDLE)
            pad_done_reg <= 1'b0;
        else if (cmd.pad_wr)
            pad_done_reg <= 1'b1;
    end
    assign pad_pending = pad_done_reg;

    assign out_sel = sel_reg;

endmodule
`default_nettype wire

// ===== design/sha256_message_digest.sv =====
`default_nettype none
// SHA-256 digest engine, one message byte per request.
// Input channel: valid/ready with data_byte, byte_present, message_end.
//   byte_present=0 with message_end=1 closes the message without a byte
//   (an empty message is allowed).
// Output channel: valid/ready, eight requests per message: digest_word,
//   word_index 0..7 (0 most significant), last_word high on the eighth.
// Flow: a byte that does not fill the 64-byte buffer is written while ready stays high.
//   A full buffer is followed by schedule loading from the byte buffer
//   (one word per cycle), 64 rounds and one fold; input ready is low
//   throughout, so no new byte is taken until the block is done. The
//   round unit does one round per cycle.
// An end mark walks the padding one byte a cycle, then runs one or two
//   final compressions, then offers the 8 digest words. Input ready is
//   low until the last word is taken.
// A stalled receiver simply holds the current word; nothing is lost.
// Reset loads the initial hash values and clears position and length;
//   the byte buffer is not cleared.
module sha256_message_digest
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        message_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    sha_cmd_t   cmd;
    sha_stat_t  stat;
    logic [2:0] sel;

    sha_control u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (in_valid),
        .ready        (in_ready),
        .byte_present (byte_present),
        .message_end  (message_end),
        .stat         (stat),
        .cmd          (cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_sel      (sel)
    );

    sha_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .out_sel     (sel),
        .stat        (stat),
        .digest_word (digest_word)
    );

    assign word_index = sel;
    assign last_word  = (sel == 3'd7);

endmodule
`default_nettype wire

// ===== tb/sha256_checker.sv =====
`timescale 1ns / 100ps
// Watches both channels, predicts each digest word and compares.
module sha256_checker
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        message_end,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [31:0] digest_word,
    input  wire logic [2:0]  word_index,
    input  wire logic        last_word,
    output int               fail_count,
    output int               pending
);

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_out_t;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    logic [5:0]   fill_pos;
    logic [63:0]  msg_bits;
    digest_out_t  digest_q [$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int k = 0; k < 16; k++)
            w[k] = {msg_block[4*k], msg_block[4*k+1], msg_block[4*k+2], msg_block[4*k+3]};
        for (int k = 0; k < 8; k++)
            v[k] = hash_state[k];
        for (int r = 0; r < 64; r++)
        begin
            if (r >= 16)
            begin
                s0 = ror32(w[(r-15)%16], 7) ^ ror32(w[(r-15)%16], 18) ^ (w[(r-15)%16] >> 3);
                s1 = ror32(w[(r-2)%16], 17) ^ ror32(w[(r-2)%16], 19) ^ (w[(r-2)%16] >> 10);
                w[r%16] = w[r%16] + s0 + w[(r-7)%16] + s1;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r%16];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
            hash_state[k] += v[k];
    endtask

    task automatic absorb_request(input logic [7:0] b, input logic p, input logic e);
        int pos;
        digest_out_t d;
        if (p)
        begin
            msg_block[fill_pos] = b;
            msg_bits += 64'd8;
            fill_pos = fill_pos + 6'd1;
            if (fill_pos == 6'd0)
                compress_block();
        end
        if (!e)
            return;
        pos = fill_pos;
        msg_block[pos] = PAD_BYTE;
        pos++;
        if (pos > LEN_OFFSET)
        begin
            for (int k = pos; k < 64; k++)
                msg_block[k] = 8'h00;
            compress_block();
            pos = 0;
        end
        for (int k = pos; k < LEN_OFFSET; k++)
            msg_block[k] = 8'h00;
        for (int j = 0; j < 8; j++)
            msg_block[LEN_OFFSET + j] = msg_bits[63 - 8*j -: 8];
        compress_block();
        for (int j = 0; j < 8; j++)
        begin
            d.word = hash_state[j];
            d.idx  = 3'(j);
            d.last = (j == 7);
            digest_q.push_back(d);
        end
        for (int k = 0; k < 8; k++)
            hash_state[k] = SHA_IV[k];
        fill_pos = '0;
        msg_bits = '0;
    endtask

    initial
    begin
        fail_count = 0;
        for (int k = 0; k < 8; k++)
            hash_state[k] = SHA_IV[k];
        fill_pos = '0;
        msg_bits = '0;
    end

    always @(posedge clk)
    begin
        digest_out_t d;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                absorb_request(data_byte, byte_present, message_end);
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected digest word %h idx %0d", digest_word, word_index);
                end
                else
                begin
                    d = digest_q.pop_front();
                    if (digest_word !== d.word || word_index !== d.idx
                        || last_word !== d.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     d.word, d.idx, d.last,
                                     digest_word, word_index, last_word);
                    end
                end
            end
        end
        pending = digest_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        message_end;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    int          fail_count;
    int          pending;

    // receiver pressure request from the stimulus process
    logic        hold_req = 1'b0;
    int          reqs_sent = 0;

    always #2 clk = ~clk;

    sha256_message_digest dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .byte_present(byte_present), .message_end(message_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    sha256_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .byte_present(byte_present), .message_end(message_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
        .fail_count(fail_count), .pending(pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 60);
        else if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // One request on the input channel. Valid stays up across back-to-back
    // requests; in_ready is looked at on the falling edge, where it is
    // stable for the coming rising edge.
    task automatic send_req(input logic [7:0] b, input logic p, input logic e);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        byte_present <= p;
        message_end  <= e;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
        reqs_sent++;
    endtask

    // whole message: bytes, end mark either on the last byte or alone
    task automatic send_message(input int len);
        logic alone;
        alone = (len == 0) || ($urandom_range(0, 1) == 0);
        for (int i = 0; i < len; i++)
        begin
            // stray no-op request now and then
            if ($urandom_range(0, 19) == 0)
                send_req(8'($urandom), 1'b0, 1'b0);
            send_req(8'($urandom), 1'b1, (i == len - 1) && !alone);
        end
        if (alone)
            send_req(8'($urandom), 1'b0, 1'b1);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (500) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        byte_present = 1'b0;
        message_end  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, byte with end mark, all-ones byte and
        // a no-op request then a lone end mark, a short mixed message
        send_req(8'h00, 1'b0, 1'b1);
        send_req(8'h00, 1'b1, 1'b1);
        send_req(8'hff, 1'b1, 1'b0);
        send_req(8'h5a, 1'b0, 1'b0);
        send_req(8'h00, 1'b0, 1'b1);
        send_req(8'h61, 1'b1, 1'b0);
        send_req(8'h62, 1'b1, 1'b0);
        send_req(8'h63, 1'b1, 1'b1);

        // long receiver hold-off while messages keep coming
        hold_req = 1'b1;

        // one message near the padding boundary, then short random ones
        send_message(55 + $urandom_range(0, 9));
        while (reqs_sent < 100)
            send_message($urandom_range(0, 8));
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("[sha256_message_digest] OK");
        else
            $display("[sha256_message_digest] ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("[sha256_message_digest] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/sha_pkg.sv
design/sha_datapath.sv
design/sha_control.sv
design/sha256_message_digest.sv
tb/sha256_checker.sv
tb/testbench.sv
